// ----- src/hpa_pkg.sv -----
// Shared definitions for the handle pool allocator.
// Operation and status codes, field widths and the default pool size.
// No dependencies.
package hpa_pkg;

  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int HANDLE_W   = 8;
  localparam int POOL_SIZE_DEFAULT = 256;

  // Operation decode bits
  localparam int OP_TRY_BIT  = 0;
  localparam int OP_FREE_BIT = 1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

endpackage

// ----- src/hpa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Used for the freed-handle queue and the in-use bitmap. No dependencies.
module hpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/handle_pool_allocator_core.sv -----
// Handle pool allocator core: free-list queue and in-use bitmap in RAM.
// Depends on hpa_pkg and hpa_ram.
//
// Usage:
//   Request channel (request_valid/request_ready) carries operation and
//   free_handle. Operation 0 allocates, 1 tries to allocate from freed
//   handles only, 2 (and 3) returns free_handle to the pool.
//   Result channel (result_valid/result_ready) carries status and
//   granted_handle, exactly one item per request, in request order.
//   With the output register free, a request reads the queue head and
//   the bitmap entry when it is accepted (registered RAM reads), then
//   decides and writes back in the next cycle; result_valid rises once
//   that commit is registered. No new request is taken until the
//   current one commits.
//   A finished result sits in an output register; the next request is
//   accepted meanwhile and waits in its decide step while the receiver
//   stalls, then completes as soon as the output register frees.
//   Reset clears queue pointers, counts and the fresh-handle counter.
//   No clearing pass: a bitmap entry at or above the fresh-handle count
//   reads as not in use, so the block takes requests right after reset.
module handle_pool_allocator_core #(
  parameter int POOL_SIZE = hpa_pkg::POOL_SIZE_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           request_valid,
  output logic                           request_ready,
  input  logic [hpa_pkg::OP_W-1:0]       operation,
  input  logic [hpa_pkg::HANDLE_W-1:0]   free_handle,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [hpa_pkg::STATUS_W-1:0]   status,
  output logic [hpa_pkg::HANDLE_W-1:0]   granted_handle
);

  import hpa_pkg::*;

  localparam int QW        = $clog2(POOL_SIZE);
  localparam int CW        = $clog2(POOL_SIZE + 1);
  localparam int MAP_DEPTH = (POOL_SIZE < (1 << HANDLE_W)) ? POOL_SIZE : (1 << HANDLE_W);
  localparam int MW        = $clog2(MAP_DEPTH);
  localparam int XW        = CW + HANDLE_W;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  logic [0:0]          state;
  logic [OP_W-1:0]     op;
  logic [HANDLE_W-1:0] handle;
  logic [QW-1:0]       head;
  logic [QW-1:0]       tail;
  logic [CW-1:0]       count;
  logic [CW-1:0]       fresh;

  logic                fifo_we;
  logic [HANDLE_W-1:0] fifo_rdata;
  logic                map_we;
  logic [MW-1:0]       map_waddr;
  logic                map_wdata;
  logic [MW-1:0]       map_raddr;
  logic                map_rdata;

  logic                accept;
  logic                commit;
  logic [XW-1:0]       handle_x;
  logic [XW-1:0]       fresh_x;
  logic [XW-1:0]       map_limit_x;
  logic                in_use;
  logic                do_free;
  logic                do_pop;
  logic                do_fresh;
  logic [STATUS_W-1:0] status_next;
  logic [HANDLE_W-1:0] grant_next;

  assign request_ready = (state == S_IDLE);
  assign accept        = request_valid && request_ready;
  assign commit        = (state == S_EXEC) && (!result_valid || result_ready);

  // Widen handle and counter to a common width for compares and selects
  assign handle_x    = {{CW{1'b0}}, free_handle};
  assign fresh_x     = {{HANDLE_W{1'b0}}, fresh};
  assign map_limit_x = XW'(MAP_DEPTH);
  assign map_raddr   = handle_x[MW-1:0];

  // Entries at or above the fresh count were never written: not in use
  assign in_use = ({{CW{1'b0}}, handle} < fresh_x) && map_rdata;

  // Decide the request from the RAM read data
  always_comb begin
    do_free     = 1'b0;
    do_pop      = 1'b0;
    do_fresh    = 1'b0;
    status_next = ST_NONE;
    grant_next  = '0;
    if (op[OP_FREE_BIT]) begin
      if (in_use && (count != CW'(POOL_SIZE))) begin
        do_free     = 1'b1;
        status_next = ST_OK;
      end else begin
        status_next = ST_INVALID;
      end
    end else if (count != '0) begin
      do_pop      = 1'b1;
      status_next = ST_OK;
      grant_next  = fifo_rdata;
    end else if (!op[OP_TRY_BIT] && (fresh != CW'(POOL_SIZE))) begin
      do_fresh    = 1'b1;
      status_next = ST_OK;
      grant_next  = fresh_x[HANDLE_W-1:0];
    end
  end

  // Queue push on free, bitmap update on free, pop or fresh grant
  always_comb begin
    fifo_we   = commit && do_free;
    map_we    = 1'b0;
    map_waddr = '0;
    map_wdata = 1'b0;
    if (commit && do_free) begin
      map_we    = 1'b1;
      map_waddr = handle[MW-1:0];
      map_wdata = 1'b0;
    end else if (commit && do_pop) begin
      map_we    = 1'b1;
      map_waddr = fifo_rdata[MW-1:0];
      map_wdata = 1'b1;
    end else if (commit && do_fresh && (fresh_x < map_limit_x)) begin
      map_we    = 1'b1;
      map_waddr = fresh_x[MW-1:0];
      map_wdata = 1'b1;
    end
  end

  hpa_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (POOL_SIZE)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail),
    .wdata (handle),
    .re    (accept),
    .raddr (head),
    .rdata (fifo_rdata)
  );

  hpa_ram #(
    .WIDTH (1),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (accept),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Sequence: read on accept, decide and write back on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Latch the request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= operation;
      handle <= free_handle;
    end
  end

  // Advance queue pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      fresh <= '0;
    end else if (commit) begin
      if (do_free) begin
        tail  <= (tail == QW'(POOL_SIZE - 1)) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end else if (do_pop) begin
        head  <= (head == QW'(POOL_SIZE - 1)) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end else if (do_fresh) begin
        fresh <= fresh + 1'b1;
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status         <= status_next;
      granted_handle <= grant_next;
    end
  end

endmodule
